/* rtl/dqr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dqr_pkg: shared types and constants for the double-ended queue
// Word and command layouts, action and status codes, controller states.
// ----------------------------------------------------------------------------
package dqr_pkg;

	localparam int DEPTH     = 32;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_LIST       = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4
	} dqr_action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_UNDERFLOW = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} dqr_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_LIST = 1'b1
	} dqr_state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} dqr_cmd_t;

	typedef struct packed {
		logic signed [31:0] entry;
		logic [1:0]         status;
		logic               last;
	} dqr_rsp_t;

endpackage : dqr_pkg
`default_nettype wire

/* rtl/double_ended_queue_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_ring: bounded double-ended queue in a ring memory
// Pushes and pops at either end, and a front-to-back listing of all words.
// ----------------------------------------------------------------------------
// A push or pop leaves busy low, and its single status word appears on rsp
// with done high in the cycle after start. A listing of N words holds busy
// high while it reads, one synchronous memory read per cycle, and the words
// follow one per cycle, each in the cycle after its read, the last one
// flagged. Listing an empty queue answers at once like a push or pop.
// Action codes five to seven are dropped without a reply. done marks each
// reply word and the receiver has no way to stall it.
module double_ended_queue_ring
	import dqr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire dqr_cmd_t cmd,
	output logic          done,
	output dqr_rsp_t      rsp
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	dqr_state_t        state_q, state_d;
	logic [IDX_W-1:0]  front_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q, rem_q;
	logic              done_q;
	dqr_status_t       status_q;
	logic              pend_s1, last_s1;
	logic signed [WORD_BITS-1:0] rdata_s1;

	logic              accept, full, empty;
	logic              do_push, do_push_front, mem_we, list_rd;
	logic [IDX_W-1:0]  front_dec, front_inc, back_slot, wr_slot, rd_ptr_inc;
	logic [CNT_W:0]    back_sum;
	dqr_action_t       act;

	assign act    = dqr_action_t'(cmd.action);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	assign front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc  = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign back_sum   = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
	assign back_slot  = (back_sum >= (CNT_W + 1)'(DEPTH))
		? IDX_W'(back_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(back_sum);

	assign do_push       = accept && !full &&
		(act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK);
	assign do_push_front = (act == ACT_PUSH_FRONT);
	assign wr_slot       = do_push_front ? front_dec : back_slot;
	assign mem_we        = do_push;

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		list_rd = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && act == ACT_LIST && !empty) begin
					state_d = ST_LIST;
				end
			end
			ST_LIST: begin
				busy    = 1'b1;
				list_rd = 1'b1;
				if (rem_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_OK;
			pend_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			pend_s1 <= list_rd;
			last_s1 <= (rem_q == CNT_W'(1));
			if (list_rd) begin
				rd_ptr_q <= rd_ptr_inc;
				rem_q    <= rem_q - 1'b1;
			end
			if (accept) begin
				case (act)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						done_q <= 1'b1;
						if (full) begin
							status_q <= STAT_OVERFLOW;
						end else begin
							status_q <= STAT_OK;
							count_q  <= count_q + 1'b1;
							if (do_push_front) begin
								front_q <= front_dec;
							end
						end
					end
					ACT_LIST: begin
						if (empty) begin
							done_q   <= 1'b1;
							status_q <= STAT_EMPTY;
						end else begin
							rd_ptr_q <= front_q;
							rem_q    <= count_q;
						end
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						done_q <= 1'b1;
						if (empty) begin
							status_q <= STAT_UNDERFLOW;
						end else begin
							status_q <= STAT_OK;
							count_q  <= count_q - 1'b1;
							if (act == ACT_POP_FRONT) begin
								front_q <= front_inc;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_slot] <= WORD_BITS'(cmd.value);
		end
		if (list_rd) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	always_comb begin
		done = done_q || pend_s1;
		if (pend_s1) begin
			rsp.entry  = 32'(rdata_s1);
			rsp.status = STAT_OK;
			rsp.last   = last_s1;
		end else begin
			rsp.entry  = '0;
			rsp.status = status_q;
			rsp.last   = 1'b1;
		end
	end

endmodule : double_ended_queue_ring
`default_nettype wire

/* verif/double_ended_queue_ring_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_ring_tb: self-checking bench for the ring-memory deque
// Sends pushes, pops, listings and unused codes with random spacing. A shadow
// deque predicts every status word and listed entry. Each strobed reply is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_tb;
	import dqr_pkg::*;

	localparam int MAX_GAP     = 17;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CODE_SPAN   = 2 ** $bits(dqr_action_t);

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	logic     busy;
	dqr_cmd_t cmd    = '0;
	logic     done;
	dqr_rsp_t rsp;

	logic signed [WORD_BITS-1:0] shadow_ring [DEPTH];
	int unsigned shadow_front = 0;
	int unsigned shadow_level = 0;
	dqr_rsp_t    awaited_words [$];

	event tick_seen;
	bit   word_taken  = 1'b0;
	int   gap_ceiling = MAX_GAP;
	int   cycle_count = 0;
	int   error_count = 0;
	int   push_count = 0, overflow_count = 0, pop_count = 0, underflow_count = 0;
	int   list_count = 0, listed_count = 0, dropped_count = 0, checked_count = 0;

	always #1 clk = ~clk;

	double_ended_queue_ring dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	function automatic void await_reply(input logic signed [31:0] entry, input dqr_status_t status,
			input logic last);
		dqr_rsp_t w;
		w.entry  = entry;
		w.status = status;
		w.last   = last;
		awaited_words.push_back(w);
	endfunction

	function automatic void model_deque_action(input dqr_cmd_t c);
		int unsigned slot;
		case (c.action)
		ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
			push_count++;
			if (shadow_level == DEPTH) begin
				overflow_count++;
				await_reply('0, STAT_OVERFLOW, 1'b1);
			end else begin
				if (c.action == ACT_PUSH_FRONT) begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					slot = shadow_front;
				end else begin
					slot = (shadow_front + shadow_level) % DEPTH;
				end
				shadow_ring[slot] = c.value;
				shadow_level++;
				await_reply('0, STAT_OK, 1'b1);
			end
		end
		ACT_LIST: begin
			list_count++;
			if (shadow_level == 0) begin
				await_reply('0, STAT_EMPTY, 1'b1);
			end else begin
				for (int unsigned k = 0; k < shadow_level; k++) begin
					await_reply(shadow_ring[(shadow_front + k) % DEPTH], STAT_OK,
						k + 1 == shadow_level);
					listed_count++;
				end
			end
		end
		ACT_POP_FRONT, ACT_POP_BACK: begin
			pop_count++;
			if (shadow_level == 0) begin
				underflow_count++;
				await_reply('0, STAT_UNDERFLOW, 1'b1);
			end else begin
				if (c.action == ACT_POP_FRONT)
					shadow_front = (shadow_front + 1) % DEPTH;
				shadow_level--;
				await_reply('0, STAT_OK, 1'b1);
			end
		end
		default: dropped_count++;
		endcase
	endfunction

	always @(posedge clk) begin : reply_check
		dqr_rsp_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("double_ended_queue_ring: mismatch");
			$finish;
		end else begin
			word_taken = 1'b0;
			if (arst_n) begin
				if (done) begin
					checked_count++;
					if (awaited_words.size() == 0) begin
						$error("unexpected word: entry %0d status %0d last %0b",
							rsp.entry, rsp.status, rsp.last);
						error_count++;
					end else begin
						want = awaited_words.pop_front();
						if (rsp.entry !== want.entry) begin
							$error("entry: expected %0d, got %0d", want.entry, rsp.entry);
							error_count++;
						end
						if (rsp.status !== want.status) begin
							$error("status: expected %0d, got %0d", want.status, rsp.status);
							error_count++;
						end
						if (rsp.last !== want.last) begin
							$error("last: expected %0b, got %0b", want.last, rsp.last);
							error_count++;
						end
					end
				end
				if (start && !busy) begin
					word_taken = 1'b1;
					model_deque_action(cmd);
				end
			end
			-> tick_seen;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [2:0] action, input logic signed [31:0] value);
		int gap;
		gap = $urandom_range(0, gap_ceiling);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(tick_seen);
		end
		cmd.action <= action;
		cmd.value  <= value;
		start      <= 1'b1;
		do @(tick_seen); while (!word_taken);
	endtask

	task automatic test_directed();
		gap_ceiling = MAX_GAP;
		send_word(ACT_LIST, pick_value());
		send_word(ACT_POP_FRONT, pick_value());
		send_word(ACT_POP_BACK, pick_value());
		send_word(ACT_PUSH_BACK, 32'sh7FFF_FFFF);
		send_word(ACT_PUSH_BACK, 32'sh8000_0000);
		send_word(ACT_PUSH_FRONT, '1);
		send_word(ACT_PUSH_FRONT, '0);
		send_word(ACT_LIST, '0);
		send_word(ACT_POP_BACK, '1);
		send_word(ACT_LIST, '1);
		send_word(ACT_POP_FRONT, 32'sh5555_AAAA);
		send_word(ACT_LIST, 32'shAAAA_5555);
		for (int code = int'(ACT_POP_BACK) + 1; code < CODE_SPAN; code++)
			send_word(3'(code), pick_value());
		send_word(ACT_POP_BACK, '0);
		send_word(ACT_POP_BACK, '0);
		send_word(ACT_POP_BACK, '0);
		send_word(ACT_PUSH_FRONT, 32'sd1);
		send_word(ACT_LIST, '0);
		send_word(ACT_POP_FRONT, '0);
		send_word(ACT_LIST, '0);
	endtask

	task automatic test_fill_to_overflow();
		gap_ceiling = MAX_GAP;
		while (shadow_level < DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				send_word(ACT_LIST, pick_value());
			else
				send_word($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
		end
		send_word(ACT_LIST, pick_value());
		send_word(ACT_PUSH_FRONT, pick_value());
		send_word(ACT_PUSH_BACK, pick_value());
		send_word(ACT_POP_BACK, pick_value());
		send_word(ACT_PUSH_FRONT, pick_value());
		send_word(ACT_PUSH_BACK, pick_value());
		send_word(ACT_LIST, pick_value());
	endtask

	task automatic test_drain_to_underflow();
		gap_ceiling = 0;
		while (shadow_level > 0) begin
			if ($urandom_range(0, 7) == 0)
				send_word(ACT_LIST, pick_value());
			else
				send_word($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, pick_value());
		end
		send_word(ACT_POP_FRONT, pick_value());
		send_word(ACT_POP_BACK, pick_value());
		send_word(ACT_LIST, pick_value());
	endtask

	task automatic test_random_mix();
		int sent;
		int pick;
		sent = 0;
		while (sent < 16) begin
			if (sent % 8 == 0)
				gap_ceiling = ((sent / 8) % 2) ? 0 : MAX_GAP;
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_word(3'($urandom_range(int'(ACT_POP_BACK) + 1, CODE_SPAN - 1)), pick_value());
			end else begin
				if (pick < 50)
					send_word($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
				else if (pick < 85)
					send_word($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, pick_value());
				else
					send_word(ACT_LIST, pick_value());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(tick_seen);
		arst_n <= 1'b1;
		@(tick_seen);
		test_directed();
		test_fill_to_overflow();
		test_drain_to_underflow();
		test_random_mix();
		start <= 1'b0;
		while (awaited_words.size() != 0) @(tick_seen);
		repeat (8) @(tick_seen);
		$display("covered %0d pushes (%0d refused full), %0d pops (%0d on empty), %0d listings",
			push_count, overflow_count, pop_count, underflow_count, list_count);
		$display("%0d entries listed, %0d unused codes dropped, %0d replies checked, %0d errors",
			listed_count, dropped_count, checked_count, error_count);
		if (error_count == 0)
			$display("double_ended_queue_ring: match");
		else
			$display("double_ended_queue_ring: mismatch");
		$finish;
	end

endmodule
